@@ hw/rtl/ptq_pkg.sv @@
package ptq_pkg;

	localparam int unsigned TIME_W = 64;
	localparam int unsigned WIN_W  = 32;
	localparam int unsigned IDX_W  = 4;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_UNSET   = 2'd1,
		OP_TRIGGER = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PK_EXEC  = 2'd0,
		PK_PEND  = 2'd1,
		PK_FINAL = 2'd2
	} push_kind_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_START  = 3'd1,
		S_EXEC   = 3'd2,
		S_SCAN   = 3'd3,
		S_DRAIN  = 3'd4,
		S_DECIDE = 3'd5,
		S_PEND   = 3'd6,
		S_FINAL  = 3'd7
	} state_t;

	// One latched request beat
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  timer_index;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] interval_time;
		logic              absolute_flag;
		logic              interval_only_flag;
		logic [TIME_W-1:0] current_time;
		logic              force_flag;
	} req_t;

	// Controller to datapath
	typedef struct packed {
		logic       op_init;
		logic       scan_init;
		logic       scan_step;
		logic       exec;
		logic       fire_commit;
		logic       pend_load;
		logic       push;
		push_kind_t push_kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic fire;
		logic out_free;
		logic pend_v;
	} stat_t;

	// Saturating 64-bit add
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ptq_ctrl.sv @@
module ptq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_beat,
	input  ptq_pkg::op_t    op,
	input  ptq_pkg::stat_t  st,
	output ptq_pkg::cmd_t   cmd,
	output logic            ready
);
	import ptq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (in_beat) state_d = S_START;
			end
			S_START: begin
				if (op == OP_SET || op == OP_UNSET) begin
					state_d = S_EXEC;
				end else begin
					cmd.op_init   = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_EXEC: begin
				if (st.out_free) begin
					cmd.exec      = 1'b1;
					cmd.push      = 1'b1;
					cmd.push_kind = PK_EXEC;
					state_d       = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (op == OP_QUERY || !st.fire) begin
					state_d = S_FINAL;
				end else begin
					cmd.fire_commit = 1'b1;
					if (st.pend_v) begin
						state_d = S_PEND;
					end else begin
						cmd.pend_load = 1'b1;
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_PEND: begin
				// release the previous fire, hold the new one until the next pick
				if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = PK_PEND;
					cmd.pend_load = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_FINAL: begin
				if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = PK_FINAL;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/ptq_dpath.sv @@
module ptq_dpath #(
	parameter int TIMER_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptq_pkg::req_t                 req,
	input  logic [ptq_pkg::WIN_W-1:0]     window,
	input  ptq_pkg::cmd_t                 cmd,
	output ptq_pkg::stat_t                st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          fired_valid,
	output logic [ptq_pkg::IDX_W-1:0]     fired_timer,
	output logic                          last_result,
	output ptq_pkg::status_t              status,
	output logic [ptq_pkg::TIME_W-1:0]    earliest_due
);
	import ptq_pkg::*;

	localparam int IW = $clog2(TIMER_COUNT);

	logic [TIME_W-1:0] due_mem [TIMER_COUNT];
	logic [TIME_W-1:0] per_mem [TIMER_COUNT];

	logic [TIMER_COUNT-1:0] armed_q, done_q, wr_q;
	logic [IW-1:0]          rd_addr_q, idx_s1, best_idx_q, pend_idx_q;
	logic                   rd_v_s1, found_q, first_q, pend_v_q;
	logic [TIME_W-1:0]      due_rd_s1, per_rd_s1, best_due_q, best_per_q, limit_q;

	logic                   out_v_q, out_fv_q, out_last_q;
	logic [IDX_W-1:0]       out_idx_q;
	status_t                out_st_q;
	logic [TIME_W-1:0]      out_due_q;

	logic              idx_ok, exec_bad, is_set, set_wr_due, cand_take, fire, out_free;
	logic              due_we, per_we;
	logic [IW-1:0]     req_idx, waddr;
	logic [TIME_W-1:0] set_sum, set_due, cand_due, next_due, wdata;

	always_comb begin
		idx_ok     = 32'(req.timer_index) < 32'(TIMER_COUNT);
		req_idx    = IW'(req.timer_index);
		is_set     = req.op == OP_SET;
		exec_bad   = !idx_ok ||
			(is_set && req.start_time == '0 && req.interval_time == '0);
		set_sum    = sat_add(req.current_time,
			(req.start_time == '0) ? req.interval_time : req.start_time);
		set_due    = (req.start_time != '0 && req.absolute_flag) ? req.start_time : set_sum;
		set_wr_due = req.start_time != '0 || !req.interval_only_flag;

		// never-written entries read as zero
		cand_due  = wr_q[idx_s1] ? due_rd_s1 : '0;
		cand_take = rd_v_s1 && armed_q[idx_s1] && !done_q[idx_s1] &&
			(!found_q || cand_due < best_due_q);

		fire     = found_q && ((first_q && req.force_flag) || best_due_q <= limit_q);
		next_due = sat_add(best_due_q, best_per_q);

		due_we = (cmd.exec && is_set && !exec_bad && set_wr_due) ||
			(cmd.fire_commit && best_per_q != '0);
		per_we = cmd.exec && is_set && !exec_bad;
		waddr  = cmd.exec ? req_idx : best_idx_q;
		wdata  = cmd.exec ? set_due : next_due;

		out_free = !out_v_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (due_we) due_mem[waddr] <= wdata;
		if (per_we) per_mem[req_idx] <= req.interval_time;
		if (cmd.scan_step) begin
			due_rd_s1 <= due_mem[rd_addr_q];
			per_rd_s1 <= per_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= '0;
			done_q    <= '0;
			wr_q      <= '0;
			rd_addr_q <= '0;
			rd_v_s1   <= 1'b0;
			found_q   <= 1'b0;
			first_q   <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				rd_addr_q <= '0;
				found_q   <= 1'b0;
			end else begin
				if (cmd.scan_step) rd_addr_q <= rd_addr_q + 1'b1;
				if (cand_take) found_q <= 1'b1;
			end
			if (cmd.op_init) begin
				done_q   <= '0;
				first_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
			if (cmd.exec && !exec_bad) begin
				armed_q[req_idx] <= is_set;
				if (is_set && set_wr_due) wr_q[req_idx] <= 1'b1;
			end
			if (cmd.fire_commit) begin
				done_q[best_idx_q] <= 1'b1;
				first_q            <= 1'b0;
				if (best_per_q == '0) begin
					armed_q[best_idx_q] <= 1'b0;
				end else begin
					wr_q[best_idx_q] <= 1'b1;
				end
			end
			if (cmd.pend_load) pend_v_q <= 1'b1;
			if (cmd.push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) idx_s1 <= rd_addr_q;
		if (cmd.op_init) limit_q <= sat_add(req.current_time, {{(TIME_W-WIN_W){1'b0}}, window});
		if (cand_take && !cmd.scan_init) begin
			best_due_q <= cand_due;
			best_per_q <= per_rd_s1;
			best_idx_q <= idx_s1;
		end
		if (cmd.pend_load) pend_idx_q <= best_idx_q;
		if (cmd.push) begin
			case (cmd.push_kind)
				PK_EXEC: begin
					out_fv_q   <= 1'b0;
					out_idx_q  <= '0;
					out_last_q <= 1'b1;
					out_st_q   <= exec_bad ? ST_BAD : ST_OK;
					out_due_q  <= '0;
				end
				PK_PEND: begin
					out_fv_q   <= 1'b1;
					out_idx_q  <= IDX_W'(pend_idx_q);
					out_last_q <= 1'b0;
					out_st_q   <= ST_OK;
					out_due_q  <= '0;
				end
				PK_FINAL: begin
					out_last_q <= 1'b1;
					if (req.op != OP_QUERY && pend_v_q) begin
						out_fv_q  <= 1'b1;
						out_idx_q <= IDX_W'(pend_idx_q);
						out_st_q  <= ST_OK;
						out_due_q <= '0;
					end else begin
						out_fv_q  <= 1'b0;
						out_idx_q <= '0;
						out_st_q  <= found_q ? ST_OK : ST_NONE;
						out_due_q <= (req.op == OP_QUERY && found_q) ? best_due_q : '0;
					end
				end
				default: begin
					out_fv_q   <= 1'b0;
					out_idx_q  <= '0;
					out_last_q <= 1'b1;
					out_st_q   <= ST_OK;
					out_due_q  <= '0;
				end
			endcase
		end
	end

	assign st.scan_last = rd_addr_q == IW'(TIMER_COUNT - 1);
	assign st.fire      = fire;
	assign st.out_free  = out_free;
	assign st.pend_v    = pend_v_q;

	assign out_valid    = out_v_q;
	assign fired_valid  = out_fv_q;
	assign fired_timer  = out_idx_q;
	assign last_result  = out_last_q;
	assign status       = out_st_q;
	assign earliest_due = out_due_q;

endmodule

@@ hw/rtl/periodic_timer_queue_core.sv @@
// Timer table with sorted firing. One request beat enters on the slave stream:
// tuser carries the operation (set, unset, trigger, query), tdata the slot,
// start, period, flags and the present time. Results leave on the master
// stream, one beat per fired timer, tlast on the final beat of a request;
// tuser marks a beat that names a fired timer. cfg_we/cfg_wdata write the
// coalescing window; write it only while no request is in flight.
// Every pick of a query or trigger is a full pass over the due/period
// memories, one entry per cycle through their single read port, then a
// drain step to flush the read stage and a decide step to compare against
// the window and write the re-armed due time back; each fire after the
// first adds a step to release the held beat. Set and unset skip the pass.
// One request is worked on at a time; s_axis_tready is high only when the
// controller is idle. A fired beat is held until the next pick decides
// whether it is the last one.
// Reset clears all armed marks and sets the window to 1 ms; due times
// never written read as zero. A stalled master side holds the result
// register and the controller waits, so no beat is ever dropped.
module periodic_timer_queue_core #(
	parameter int TIMER_COUNT = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [3:0] timer_index, [67:4] start_time, [131:68] interval_time,
	// [132] absolute_flag, [133] interval_only_flag, [197:134] current_time,
	// [198] force_flag, [199] zero
	input  logic [199:0] s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] fired_timer, [5:4] status, [69:6] earliest_due, [71:70] zero
	output logic [71:0]  m_axis_tdata,
	// [0] fired_valid
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);
	import ptq_pkg::*;

	logic [WIN_W-1:0]  window_q;
	req_t              req_q;
	cmd_t              cmd;
	stat_t             st;
	logic              in_beat;
	logic              fired_valid, last_result;
	logic [IDX_W-1:0]  fired_timer;
	status_t           status;
	logic [TIME_W-1:0] earliest_due;

	assign in_beat = s_axis_tvalid && s_axis_tready;

	// Coalescing window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Capture the request beat; it stays put until the controller is idle again
	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_q.op                 <= op_t'(s_axis_tuser);
			req_q.timer_index        <= s_axis_tdata[3:0];
			req_q.start_time         <= s_axis_tdata[67:4];
			req_q.interval_time      <= s_axis_tdata[131:68];
			req_q.absolute_flag      <= s_axis_tdata[132];
			req_q.interval_only_flag <= s_axis_tdata[133];
			req_q.current_time       <= s_axis_tdata[197:134];
			req_q.force_flag         <= s_axis_tdata[198];
		end
	end

	ptq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_beat (in_beat),
		.op      (req_q.op),
		.st      (st),
		.cmd     (cmd),
		.ready   (s_axis_tready)
	);

	ptq_dpath #(
		.TIMER_COUNT (TIMER_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_q),
		.window       (window_q),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.fired_valid  (fired_valid),
		.fired_timer  (fired_timer),
		.last_result  (last_result),
		.status       (status),
		.earliest_due (earliest_due)
	);

	// Pack the result beat
	assign m_axis_tdata = {2'b00, earliest_due, status, fired_timer};
	assign m_axis_tuser = fired_valid;
	assign m_axis_tlast = last_result;

	// A request beat closes the slave side until its work is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("request accepted while previous one still in flight");

	// A fired beat carries ok status and no due time
	a_fired_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> status == ST_OK && earliest_due == '0)
		else $error("fired beat with stray status or due time");

	// A beat naming no timer is always the only, hence last, beat of its request
	a_nofire_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && fired_timer == '0)
		else $error("non-fired beat not marked last");

	// No armed timer means no due time to report
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_NONE |-> earliest_due == '0 && !m_axis_tuser)
		else $error("empty-table result carries data");

endmodule

@@ tb/sv/periodic_timer_queue_core_test.sv @@
// Self-checking bench for the periodic timer queue core.
//
// Request beats go in on the slave stream: tuser holds the operation and
// tdata holds the slot, start, period, flags, present time and force bit.
// Response beats come back on the master stream, one per fired timer or a
// single status beat, with tlast on the final beat of each request.
// A shadow timer table runs in step with the driven requests. It queues
// every beat it expects, and the monitor compares each accepted beat field
// by field against the oldest queued one.
// The window register is rewritten only once the block has drained.
module periodic_timer_queue_core_test;
	import ptq_pkg::*;

	localparam int TIMER_COUNT = 16;
	localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	// One response beat as the block should emit it
	typedef struct {
		logic              fired;
		logic [IDX_W-1:0]  timer;
		logic              last;
		status_t           status;
		logic [TIME_W-1:0] due;
	} timer_reply_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [3:0] timer_index, [67:4] start_time, [131:68] interval_time,
	// [132] absolute_flag, [133] interval_only_flag, [197:134] current_time,
	// [198] force_flag, [199] zero
	logic [199:0] s_axis_tdata;
	// [1:0] operation
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [3:0] fired_timer, [5:4] status, [69:6] earliest_due, [71:70] zero
	logic [71:0]  m_axis_tdata;
	// [0] fired_valid
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	// Shadow timer table and window
	logic [TIME_W-1:0] tm_due [TIMER_COUNT];
	logic [TIME_W-1:0] tm_period [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] tm_armed;
	logic [WIN_W-1:0] window_ns;

	timer_reply_t reply_q[$];
	int mismatch_count;
	logic idle_on;
	int stall_left;
	logic [TIME_W-1:0] wall_ns;

	periodic_timer_queue_core #(
		.TIMER_COUNT(TIMER_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Saturating time sum: clamp to all ones on carry out
	function automatic logic [TIME_W-1:0] capped_sum(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] s;
		s = a + b;
		return (s < a) ? TIME_MAX : s;
	endfunction

	// Earliest armed slot outside skip, lower index wins ties; -1 if none
	function automatic int earliest_armed(input logic [TIMER_COUNT-1:0] skip);
		int best;
		best = -1;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			if (tm_armed[i] && !skip[i]) begin
				if (best < 0 || tm_due[i] < tm_due[best])
					best = i;
			end
		end
		return best;
	endfunction

	function automatic req_t make_req(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] period,
			input logic abs_f, input logic only_f, input logic [TIME_W-1:0] now,
			input logic frc);
		req_t r;
		r.op = op;
		r.timer_index = idx;
		r.start_time = start;
		r.interval_time = period;
		r.absolute_flag = abs_f;
		r.interval_only_flag = only_f;
		r.current_time = now;
		r.force_flag = frc;
		return r;
	endfunction

	// Advance the shadow table by one request and queue the beats it causes
	task automatic predict_reply(input req_t r);
		timer_reply_t rep;
		timer_reply_t held;
		logic [TIMER_COUNT-1:0] done;
		logic [TIME_W-1:0] limit;
		logic force_pick;
		logic have_held;
		int pick;
		rep = '{fired: 1'b0, timer: '0, last: 1'b1, status: ST_OK, due: '0};
		case (r.op)
			OP_SET: begin
				if (r.start_time == 0 && r.interval_time == 0) begin
					rep.status = ST_BAD;
				end else begin
					if (r.start_time == 0) begin
						// period-only change keeps the due time
						if (!r.interval_only_flag)
							tm_due[r.timer_index] = capped_sum(r.current_time, r.interval_time);
					end else begin
						tm_due[r.timer_index] = r.absolute_flag ? r.start_time :
							capped_sum(r.start_time, r.current_time);
					end
					tm_period[r.timer_index] = r.interval_time;
					tm_armed[r.timer_index] = 1'b1;
				end
				reply_q.push_back(rep);
			end
			OP_UNSET: begin
				tm_armed[r.timer_index] = 1'b0;
				reply_q.push_back(rep);
			end
			OP_QUERY: begin
				pick = earliest_armed('0);
				if (pick < 0)
					rep.status = ST_NONE;
				else
					rep.due = tm_due[pick];
				reply_q.push_back(rep);
			end
			default: begin
				if (earliest_armed('0) < 0) begin
					rep.status = ST_NONE;
					reply_q.push_back(rep);
				end else begin
					limit = capped_sum(r.current_time, {32'd0, window_ns});
					done = '0;
					force_pick = r.force_flag;
					have_held = 1'b0;
					held = rep;
					forever begin
						pick = earliest_armed(done);
						if (pick < 0)
							break;
						// force lets only the first pick ignore the window
						if (!force_pick && tm_due[pick] > limit)
							break;
						force_pick = 1'b0;
						done[pick] = 1'b1;
						if (tm_period[pick] != 0)
							tm_due[pick] = capped_sum(tm_due[pick], tm_period[pick]);
						else
							tm_armed[pick] = 1'b0;
						// hold each fired beat until we know whether it is the last
						if (have_held)
							reply_q.push_back(held);
						held = '{fired: 1'b1, timer: pick[IDX_W-1:0], last: 1'b0,
							status: ST_OK, due: '0};
						have_held = 1'b1;
					end
					if (have_held)
						held.last = 1'b1;
					reply_q.push_back(held);
				end
			end
		endcase
	endtask

	// Drive one request beat, predict it, and wait for the handshake
	task automatic send_timer_request(input req_t r);
		int gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r.force_flag, r.current_time, r.interval_only_flag,
			r.absolute_flag, r.interval_time, r.start_time, r.timer_index};
		s_axis_tuser <= r.op;
		predict_reply(r);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait for every queued beat to arrive
	task automatic drain_replies();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
	endtask

	// Rewrite the window only once the block has gone quiet
	task automatic write_window(input logic [WIN_W-1:0] value);
		drain_replies();
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		window_ns = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			mismatch_count = mismatch_count + 1;
		end
	endtask

	// Monitor: check every accepted response beat against the oldest expectation
	always @(posedge clk) begin
		timer_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_q.size() == 0) begin
				$display("%0t extra beat: expected none actual fv %0h idx %0h last %0h st %0h due %0h",
					$time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tlast,
					m_axis_tdata[5:4], m_axis_tdata[69:6]);
				mismatch_count = mismatch_count + 1;
			end else begin
				want = reply_q.pop_front();
				compare_field("fired_valid", 64'(want.fired), 64'(m_axis_tuser));
				compare_field("fired_timer", 64'(want.timer), 64'(m_axis_tdata[3:0]));
				compare_field("last_result", 64'(want.last), 64'(m_axis_tlast));
				compare_field("status", 64'(want.status), 64'(m_axis_tdata[5:4]));
				compare_field("earliest_due", want.due, m_axis_tdata[69:6]);
			end
		end
	end

	// Receiver stalls: tready drops low in random bursts while idling is on
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Query and trigger on an empty table
	task automatic test_empty_table();
		send_timer_request(make_req(OP_QUERY, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_TRIGGER, 4'd5, '0, '0, 1'b0, 1'b0, TIME_MAX, 1'b1));
	endtask

	// Each way of arming a timer, plus the rejected and no-op cases
	task automatic test_arm_variants();
		// zero start with zero period is rejected
		send_timer_request(make_req(OP_SET, 4'd0, '0, '0, 1'b0, 1'b0, 64'd100, 1'b0));
		// period-only change on a never-set slot leaves due at zero
		send_timer_request(make_req(OP_SET, 4'd3, '0, 64'd500, 1'b0, 1'b1, 64'd777, 1'b0));
		send_timer_request(make_req(OP_QUERY, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_SET, 4'd15, 64'd2000, '0, 1'b0, 1'b0, 64'd1000, 1'b0));
		// absolute start already in the past
		send_timer_request(make_req(OP_SET, 4'd7, 64'd100, '0, 1'b1, 1'b0, 64'd5000, 1'b0));
		send_timer_request(make_req(OP_SET, 4'd9, '0, 64'd4000, 1'b0, 1'b0, 64'd1000, 1'b0));
		// unset of an unarmed slot
		send_timer_request(make_req(OP_UNSET, 4'd12, '0, '0, 1'b0, 1'b0, '0, 1'b0));
	endtask

	// One trigger catches everything in the window; re-armed timers fire once
	task automatic test_coalesced_firing();
		send_timer_request(make_req(OP_TRIGGER, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_QUERY, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
	endtask

	// Zero window: nothing due, then force fires only the earliest
	task automatic test_zero_window();
		write_window('0);
		send_timer_request(make_req(OP_TRIGGER, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_TRIGGER, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b1));
		send_timer_request(make_req(OP_UNSET, 4'd3, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_UNSET, 4'd9, '0, '0, 1'b0, 1'b0, '0, 1'b0));
	endtask

	// Sums that clamp at the top of the time range, and ties on equal due times
	task automatic test_saturated_times();
		write_window(32'hFFFF_FFFF);
		send_timer_request(make_req(OP_SET, 4'd1, TIME_MAX, TIME_MAX, 1'b1, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_SET, 4'd2, TIME_MAX - 64'd10, 64'd5, 1'b0, 1'b0,
			64'd100, 1'b0));
		send_timer_request(make_req(OP_QUERY, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_TRIGGER, 4'd0, '0, '0, 1'b0, 1'b0, TIME_MAX, 1'b0));
		send_timer_request(make_req(OP_TRIGGER, 4'd0, '0, '0, 1'b0, 1'b0,
			64'hFFFF_FFFF_FFFF_FF00, 1'b1));
		send_timer_request(make_req(OP_UNSET, 4'd1, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_UNSET, 4'd2, '0, '0, 1'b0, 1'b0, '0, 1'b0));
		send_timer_request(make_req(OP_QUERY, 4'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
	endtask

	// Mostly coherent timelines with random content, a tenth pure noise
	task automatic send_random_item();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r = make_req(OP_QUERY, IDX_W'($urandom_range(0, 15)), '0, '0, 1'b0, 1'b0, wall_ns,
			1'b0);
		if (pick < 10) begin
			r.op = op_t'($urandom_range(0, 3));
			r.start_time = {$urandom, $urandom};
			r.interval_time = {$urandom, $urandom};
			r.absolute_flag = 1'($urandom_range(0, 1));
			r.interval_only_flag = 1'($urandom_range(0, 1));
			r.current_time = {$urandom, $urandom};
			r.force_flag = 1'($urandom_range(0, 1));
		end else if (pick < 50) begin
			r.op = OP_SET;
			r.interval_time = $urandom_range(0, 1) ? '0 : TIME_W'($urandom_range(1, 2000000));
			case ($urandom_range(0, 3))
				0: r.start_time = TIME_W'($urandom_range(1, 3000000));
				1: begin
					r.absolute_flag = 1'b1;
					r.start_time = wall_ns + TIME_W'($urandom_range(1, 3000000));
				end
				2: begin
					// absolute start behind the present time
					r.absolute_flag = 1'b1;
					r.start_time = (wall_ns >> 1) | 64'd1;
				end
				default: begin
					r.absolute_flag = 1'($urandom_range(0, 1));
					r.interval_only_flag = ($urandom_range(0, 2) == 0);
				end
			endcase
		end else if (pick < 65) begin
			r.op = OP_UNSET;
		end else if (pick < 92) begin
			r.op = OP_TRIGGER;
			wall_ns = wall_ns + TIME_W'($urandom_range(0, 2000000));
			r.current_time = wall_ns;
			r.force_flag = ($urandom_range(0, 4) == 0);
		end
		send_timer_request(r);
	endtask

	// Random traffic under one window setting, idling switched in stretches
	task automatic test_random_traffic(input int count, input logic [WIN_W-1:0] win);
		write_window(win);
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_random_item();
		end
	endtask

	// Closing stretch with both sides always ready
	task automatic test_back_to_back(input int count);
		write_window(WIN_W'($urandom_range(0, 3000000)));
		idle_on = 1'b0;
		for (int n = 0; n < count; n++)
			send_random_item();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_SET;
		m_axis_tready = 1'b1;
		stall_left = 0;
		idle_on = 1'b1;
		mismatch_count = 0;
		wall_ns = '0;
		tm_armed = '0;
		window_ns = WINDOW_RESET;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			tm_due[i] = '0;
			tm_period[i] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_arm_variants();
		test_coalesced_firing();
		test_zero_window();
		test_saturated_times();
		test_random_traffic(90, WINDOW_RESET);
		test_random_traffic(90, '0);
		test_random_traffic(90, 32'hFFFF_FFFF);
		test_random_traffic(50, $urandom);
		test_back_to_back(40);

		// Wait out the last beats, then keep the clock running to catch strays
		drain_replies();
		repeat (2 * (TIMER_COUNT + 3)) @(posedge clk);
		if (mismatch_count == 0 && reply_q.size() == 0) begin
			$display("PASS periodic_timer_queue_core");
		end else begin
			$display("FAIL periodic_timer_queue_core");
		end
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#40000000;
		$display("FAIL periodic_timer_queue_core");
		$finish;
	end

endmodule
